/* design/fmacl_pkg.sv */
// shared types and constants for the first-match ipv4 access list
// no dependencies; used by fmacl_cell and first_match_ipv4_acl
`default_nettype none

package fmacl_pkg;

    localparam int ADDR_W        = 32;
    localparam int LEN_W         = 6;
    localparam int MAX_LEN       = 32;
    localparam int MAX_RULES_DEF = 256;

    // opcode values
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // one input item
    typedef struct packed {
        logic              opcode;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  prefix_len;
        logic              allow;
    } t_in_item;

    // one result item
    typedef struct packed {
        logic permit;
        logic rule_dropped;
    } t_out_item;

    // item as it travels from cell to cell
    typedef struct packed {
        logic              valid;
        logic              opcode;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  prefix_len;
        logic              allow;
        logic              done;
        logic              verdict;
    } t_link;

endpackage

`default_nettype wire

/* design/fmacl_cell.sv */
// one rule slot of the access list chain, holding a single rule
// depends on fmacl_pkg for the link type and opcode constants
`default_nettype none

module fmacl_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire fmacl_pkg::t_link i_link,
    output fmacl_pkg::t_link     o_link,
    output logic                 o_used
);

    logic                           r_used, n_used;
    logic                           r_valid;
    fmacl_pkg::t_link               r_link, n_link;
    logic [fmacl_pkg::ADDR_W-1:0]   r_rule_addr, n_rule_addr;
    logic [fmacl_pkg::LEN_W-1:0]    r_rule_len, n_rule_len;
    logic                           r_rule_allow, n_rule_allow;
    logic                           w_hit;

    // leading-ones mask for a prefix length of 0..32
    function automatic logic [fmacl_pkg::ADDR_W-1:0] prefix_mask(
        input logic [fmacl_pkg::LEN_W-1:0] len
    );
        logic [fmacl_pkg::ADDR_W-1:0] m;
        if (len == '0) begin
            m = '0;
        end else begin
            m = {fmacl_pkg::ADDR_W{1'b1}} << (6'(fmacl_pkg::MAX_LEN) - len);
        end
        return m;
    endfunction

    // stored rule matches the passing query
    assign w_hit = r_used && (r_rule_len <= i_link.prefix_len) &&
                   (((r_rule_addr ^ i_link.address) & prefix_mask(r_rule_len)) == '0);

    // claim an empty slot on insert, resolve a query on first match
    always_comb begin
        n_link       = i_link;
        n_used       = r_used;
        n_rule_addr  = r_rule_addr;
        n_rule_len   = r_rule_len;
        n_rule_allow = r_rule_allow;
        if (i_link.valid && !i_link.done) begin
            if (i_link.opcode == fmacl_pkg::OP_INSERT) begin
                if (!r_used) begin
                    n_used       = 1'b1;
                    n_rule_addr  = i_link.address;
                    n_rule_len   = i_link.prefix_len;
                    n_rule_allow = i_link.allow;
                    n_link.done  = 1'b1;
                end
            end else if (w_hit) begin
                n_link.done    = 1'b1;
                n_link.verdict = r_rule_allow;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= 1'b0;
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_used  <= n_used;
            r_valid <= i_link.valid;
        end
    end

    // payload and rule storage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_link       <= n_link;
            r_rule_addr  <= n_rule_addr;
            r_rule_len   <= n_rule_len;
            r_rule_allow <= n_rule_allow;
        end
    end

    always_comb begin
        o_link       = r_link;
        o_link.valid = r_valid;
    end

    assign o_used = r_used;

endmodule

`default_nettype wire

/* design/first_match_ipv4_acl.sv */
// first-match ipv4 access list: a chain of MAX_RULES rule cells, one rule each
// an item is registered in each rule cell in turn and then in the output register;
// one item per cycle while no finished result is held up at the output
// depends on fmacl_pkg and fmacl_cell
// synchronous active-low reset empties every cell and the output register
`default_nettype none

module first_match_ipv4_acl #(
    parameter int MAX_RULES = fmacl_pkg::MAX_RULES_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire fmacl_pkg::t_in_item  i_in_data,
    output logic                      o_in_stall,
    output logic                      o_out_valid,
    output fmacl_pkg::t_out_item      o_out_data,
    input  wire logic                 i_out_stall
);

    fmacl_pkg::t_link     w_link [MAX_RULES+1];
    fmacl_pkg::t_link     w_head;
    logic [MAX_RULES-1:0] w_used;
    logic                 w_en;
    logic                 r_out_valid;
    fmacl_pkg::t_out_item r_out_data, n_out_data;

    // whole chain advances unless a finished result is held up
    assign w_en       = !r_out_valid || !i_out_stall;
    assign o_in_stall = !w_en;

    // chain entry, prefix length saturated to 32
    always_comb begin
        w_head.valid      = i_in_valid;
        w_head.opcode     = i_in_data.opcode;
        w_head.address    = i_in_data.address;
        w_head.prefix_len = (i_in_data.prefix_len > fmacl_pkg::LEN_W'(fmacl_pkg::MAX_LEN))
                          ? fmacl_pkg::LEN_W'(fmacl_pkg::MAX_LEN) : i_in_data.prefix_len;
        w_head.allow      = i_in_data.allow;
        w_head.done       = 1'b0;
        w_head.verdict    = 1'b0;
    end

    assign w_link[0] = w_head;

    // rule cells
    for (genvar g = 0; g < MAX_RULES; g++) begin : g_cell
        fmacl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_link  (w_link[g]),
            .o_link  (w_link[g+1]),
            .o_used  (w_used[g])
        );
    end

    // verdict at chain end: no match permits, unplaced insert is dropped
    always_comb begin
        if (w_link[MAX_RULES].opcode == fmacl_pkg::OP_INSERT) begin
            n_out_data.permit       = 1'b0;
            n_out_data.rule_dropped = !w_link[MAX_RULES].done;
        end else begin
            n_out_data.permit       = w_link[MAX_RULES].done ? w_link[MAX_RULES].verdict : 1'b1;
            n_out_data.rule_dropped = 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_link[MAX_RULES].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // occupied cells always form an unbroken run from the chain head
    a_used_thermo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_used + MAX_RULES'(1)) & w_used) == '0)
        else $error("rule cells occupied out of order");

    // a result never carries both a permit and a drop flag
    a_out_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.permit && o_out_data.rule_dropped))
        else $error("result has permit and rule_dropped together");

    // input is held off only while a result waits at the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    // once the last cell is taken, a new insert can only be dropped
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && w_used[MAX_RULES-1] && w_link[MAX_RULES].valid &&
         w_link[MAX_RULES].opcode == fmacl_pkg::OP_INSERT && !w_link[MAX_RULES].done)
        |=> (o_out_valid && o_out_data.rule_dropped))
        else $error("insert into full table not flagged");

endmodule

`default_nettype wire

/* tb/sv/first_match_ipv4_acl_test.sv */
`timescale 1ns / 1ps
// self-checking testbench for first_match_ipv4_acl: directed and random inserts and queries
// keeps its own copy of the rule table; depends on fmacl_pkg and the first_match_ipv4_acl rtl

module first_match_ipv4_acl_test;

    localparam int MAX_RULES    = fmacl_pkg::MAX_RULES_DEF;
    localparam int LATENCY      = MAX_RULES + 1;
    localparam int LIMIT_CYCLES = 400000;
    localparam int RAND_ITEMS   = 450;
    localparam int POOL_N       = 8;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 in_valid = 1'b0;
    fmacl_pkg::t_in_item  in_data  = '0;
    logic                 in_stall;
    logic                 out_valid;
    fmacl_pkg::t_out_item out_data;
    logic                 out_stall = 1'b0;

    // shadow rule table
    logic [fmacl_pkg::ADDR_W-1:0] acl_addr  [MAX_RULES];
    logic [fmacl_pkg::LEN_W-1:0]  acl_len   [MAX_RULES];
    logic                         acl_allow [MAX_RULES];
    int                           acl_count = 0;

    fmacl_pkg::t_in_item          pending_items[$];
    fmacl_pkg::t_out_item         acl_verdicts[$];
    logic [fmacl_pkg::ADDR_W-1:0] net_pool [POOL_N];

    int   err_count     = 0;
    int   cycle_count   = 0;
    int   results_seen  = 0;
    int   items_total   = 0;
    int   gen_rules     = 0;
    logic in_taken      = 1'b0;
    int   burst_left    = 0;
    int   gap_left      = 0;
    int   stall_mode    = 0;
    int   stall_left    = 0;

    always #6 clk = ~clk;

    first_match_ipv4_acl #(
        .MAX_RULES(MAX_RULES)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_data  (in_data),
        .o_in_stall (in_stall),
        .o_out_valid(out_valid),
        .o_out_data (out_data),
        .i_out_stall(out_stall)
    );

    // apply one item to the shadow table and return its verdict
    function automatic fmacl_pkg::t_out_item judge_item(fmacl_pkg::t_in_item it);
        fmacl_pkg::t_out_item         res;
        logic [fmacl_pkg::LEN_W-1:0]  len;
        logic [fmacl_pkg::ADDR_W-1:0] mask;
        logic                         found;
        res   = '0;
        found = 1'b0;
        len   = (it.prefix_len > fmacl_pkg::MAX_LEN)
              ? fmacl_pkg::LEN_W'(fmacl_pkg::MAX_LEN) : it.prefix_len;
        if (it.opcode == fmacl_pkg::OP_INSERT) begin
            if (acl_count >= MAX_RULES) begin
                res.rule_dropped = 1'b1;
            end else begin
                acl_addr[acl_count]  = it.address;
                acl_len[acl_count]   = len;
                acl_allow[acl_count] = it.allow;
                acl_count++;
            end
        end else begin
            res.permit = 1'b1;
            for (int i = 0; i < acl_count && !found; i++) begin
                if (acl_len[i] <= len) begin
                    mask = (acl_len[i] == 0) ? '0 :
                           ({fmacl_pkg::ADDR_W{1'b1}} << (fmacl_pkg::ADDR_W - int'(acl_len[i])));
                    if (((acl_addr[i] ^ it.address) & mask) == '0) begin
                        res.permit = acl_allow[i];
                        found      = 1'b1;
                    end
                end
            end
        end
        return res;
    endfunction

    // address close to one of the pool networks, random below a random depth
    function automatic logic [fmacl_pkg::ADDR_W-1:0] near_net();
        int                           depth;
        logic [fmacl_pkg::ADDR_W-1:0] low;
        depth = $urandom_range(0, fmacl_pkg::ADDR_W);
        low   = (depth == 0) ? '0
              : ({fmacl_pkg::ADDR_W{1'b1}} >> (fmacl_pkg::ADDR_W - depth));
        return net_pool[$urandom_range(0, POOL_N - 1)] ^ ($urandom & low);
    endfunction

    task automatic push_item(input logic op, input logic [fmacl_pkg::ADDR_W-1:0] addr,
                             input logic [fmacl_pkg::LEN_W-1:0] len, input logic alw);
        fmacl_pkg::t_in_item it;
        it.opcode     = op;
        it.address    = addr;
        it.prefix_len = len;
        it.allow      = alw;
        pending_items = {pending_items, it};
        if (op == fmacl_pkg::OP_INSERT) begin
            gen_rules++;
        end
    endtask

    // accept tracking, prediction and result checking
    always @(posedge clk) begin : check_results
        fmacl_pkg::t_out_item want;
        cycle_count <= cycle_count + 1;
        in_taken    <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall) begin
            acl_verdicts = {acl_verdicts, judge_item(in_data)};
        end
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (acl_verdicts.size() == 0) begin
                $display("%0t: unexpected result permit=%b rule_dropped=%b",
                         $time, out_data.permit, out_data.rule_dropped);
                err_count++;
            end else begin
                want = acl_verdicts.pop_front();
                if (out_data.permit !== want.permit) begin
                    $display("%0t: permit mismatch expected %b actual %b",
                             $time, want.permit, out_data.permit);
                    err_count++;
                end
                if (out_data.rule_dropped !== want.rule_dropped) begin
                    $display("%0t: rule_dropped mismatch expected %b actual %b",
                             $time, want.rule_dropped, out_data.rule_dropped);
                    err_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        if (cycle_count == LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    // sender bursts and receiver stall pattern
    always @(negedge clk) begin : drive_items
        logic                next_valid;
        fmacl_pkg::t_in_item next_data;
        int                  r;
        next_valid = in_valid;
        next_data  = in_data;
        if (rst_n && (!in_valid || in_taken)) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_items.size() > 0) begin
                next_valid = 1'b1;
                next_data  = pending_items.pop_front();
                if (burst_left > 0) begin
                    burst_left--;
                end
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    r          = $urandom_range(0, 3);
                    gap_left   = (r == 0) ? 0 : $urandom_range(1, r * 5);
                end
            end
        end
        in_valid <= next_valid;
        in_data  <= next_data;

        // receiver stall mode is picked anew whenever its random hold count runs out
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 150);
        end
        stall_left--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= ((cycle_count % 6) < 2);
        endcase
    end

    initial begin : run_test
        logic [fmacl_pkg::LEN_W-1:0]  len;
        logic [fmacl_pkg::ADDR_W-1:0] addr;
        for (int k = 0; k < POOL_N; k++) begin
            net_pool[k] = $urandom;
        end

        // empty table permits everything
        push_item(fmacl_pkg::OP_QUERY,  32'h0000_0000, 6'd0,  1'b1);
        push_item(fmacl_pkg::OP_QUERY,  32'hFFFF_FFFF, 6'd63, 1'b0);
        // host rule, shorter query misses it, long query length saturates
        push_item(fmacl_pkg::OP_INSERT, 32'hFFFF_FFFF, 6'd32, 1'b0);
        push_item(fmacl_pkg::OP_QUERY,  32'hFFFF_FFFF, 6'd32, 1'b1);
        push_item(fmacl_pkg::OP_QUERY,  32'hFFFF_FFFF, 6'd31, 1'b0);
        push_item(fmacl_pkg::OP_QUERY,  32'hFFFF_FFFF, 6'd63, 1'b0);
        // duplicate prefix, earlier rule wins
        push_item(fmacl_pkg::OP_INSERT, 32'hFFFF_FFFF, 6'd32, 1'b1);
        push_item(fmacl_pkg::OP_QUERY,  32'hFFFF_FFFF, 6'd32, 1'b1);
        // insert length above 32 stored as 32
        push_item(fmacl_pkg::OP_INSERT, 32'h0000_0000, 6'd40, 1'b1);
        push_item(fmacl_pkg::OP_QUERY,  32'h0000_0000, 6'd32, 1'b0);
        push_item(fmacl_pkg::OP_QUERY,  32'h0000_0000, 6'd20, 1'b0);
        // nested prefixes, first match decides
        push_item(fmacl_pkg::OP_INSERT, 32'h0A00_0000, 6'd8,  1'b0);
        push_item(fmacl_pkg::OP_INSERT, 32'h0A00_0000, 6'd16, 1'b1);
        push_item(fmacl_pkg::OP_QUERY,  32'h0A00_0102, 6'd32, 1'b1);
        push_item(fmacl_pkg::OP_QUERY,  32'h0A00_0000, 6'd7,  1'b0);
        push_item(fmacl_pkg::OP_QUERY,  32'h0B00_0000, 6'd8,  1'b1);
        push_item(fmacl_pkg::OP_INSERT, 32'h0A01_0000, 6'd16, 1'b1);
        push_item(fmacl_pkg::OP_QUERY,  32'h0A01_0203, 6'd24, 1'b0);
        push_item(fmacl_pkg::OP_INSERT, 32'h8000_0000, 6'd63, 1'b0);
        push_item(fmacl_pkg::OP_QUERY,  32'h8000_0000, 6'd33, 1'b1);
        push_item(fmacl_pkg::OP_QUERY,  32'h8000_0001, 6'd32, 1'b0);
        push_item(fmacl_pkg::OP_INSERT, 32'h5555_5555, 6'd1,  1'b1);
        push_item(fmacl_pkg::OP_QUERY,  32'hAAAA_AAAA, 6'd32, 1'b0);
        push_item(fmacl_pkg::OP_QUERY,  32'h2AAA_AAAA, 6'd2,  1'b0);

        // random mix, insert heavy until the table fills, then drops
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if ($urandom_range(1, 100) <= ((gen_rules < MAX_RULES) ? 70 : 30)) begin
                if (gen_rules == MAX_RULES - 1) begin
                    len = '0;  // last slot: catch-all rule
                end else begin
                    case ($urandom_range(0, 9))
                        0: len = fmacl_pkg::LEN_W'($urandom_range(33, 63));
                        1: len = fmacl_pkg::LEN_W'($urandom_range(0, 7));
                        default: len = fmacl_pkg::LEN_W'($urandom_range(8, 32));
                    endcase
                end
                addr = ($urandom_range(0, 4) == 0) ? $urandom : near_net();
                push_item(fmacl_pkg::OP_INSERT, addr, len, 1'($urandom_range(0, 1)));
            end else begin
                case ($urandom_range(0, 9))
                    0: len = fmacl_pkg::LEN_W'($urandom_range(33, 63));
                    1: len = fmacl_pkg::LEN_W'($urandom_range(0, 15));
                    default: len = fmacl_pkg::LEN_W'($urandom_range(16, 32));
                endcase
                addr = ($urandom_range(0, 6) == 0) ? $urandom : near_net();
                push_item(fmacl_pkg::OP_QUERY, addr, len, 1'($urandom_range(0, 1)));
            end
        end
        items_total = pending_items.size();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // one result per item, then a quiet spell for stray results
        while (results_seen < items_total) begin
            @(negedge clk);
        end
        repeat (LATENCY + 20) @(negedge clk);

        if (err_count == 0 && acl_verdicts.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
